// ----- rtl/sgrd_pkg.sv -----
// Shared types and constants of the SGR attribute decoder.
// No dependencies; imported by every module of the block.
package sgrd_pkg;

  localparam logic [1:0] KIND_DEFAULT = 2'd0;
  localparam logic [1:0] KIND_INDEXED = 2'd1;
  localparam logic [1:0] KIND_RGB     = 2'd2;

  localparam logic [15:0] SGR_RESET      = 16'd0;
  localparam logic [15:0] SGR_BOLD       = 16'd1;
  localparam logic [15:0] SGR_FAINT      = 16'd2;
  localparam logic [15:0] SGR_ITALIC     = 16'd3;
  localparam logic [15:0] SGR_UNDERLINE  = 16'd4;
  localparam logic [15:0] SGR_BLINK_SLOW = 16'd5;
  localparam logic [15:0] SGR_BLINK_FAST = 16'd6;
  localparam logic [15:0] SGR_INVERSE    = 16'd7;
  localparam logic [15:0] SGR_HIDE       = 16'd8;
  localparam logic [15:0] SGR_STRIKE     = 16'd9;
  localparam logic [15:0] SGR_NO_BOLD    = 16'd21;
  localparam logic [15:0] SGR_NORMAL     = 16'd22;
  localparam logic [15:0] SGR_NO_ITALIC  = 16'd23;
  localparam logic [15:0] SGR_NO_UNDER   = 16'd24;
  localparam logic [15:0] SGR_NO_BLINK   = 16'd25;
  localparam logic [15:0] SGR_NO_INVERSE = 16'd27;
  localparam logic [15:0] SGR_NO_HIDE    = 16'd28;
  localparam logic [15:0] SGR_NO_STRIKE  = 16'd29;
  localparam logic [15:0] SGR_FG_EXT     = 16'd38;
  localparam logic [15:0] SGR_FG_DEFAULT = 16'd39;
  localparam logic [15:0] SGR_BG_EXT     = 16'd48;
  localparam logic [15:0] SGR_BG_DEFAULT = 16'd49;
  localparam logic [15:0] SGR_FG_BASE    = 16'd30;
  localparam logic [15:0] SGR_BG_BASE    = 16'd40;
  localparam logic [15:0] SGR_FG_BRIGHT  = 16'd90;
  localparam logic [15:0] SGR_BG_BRIGHT  = 16'd100;
  localparam logic [15:0] SGR_COLOR_SPAN = 16'd7;

  localparam logic [15:0] SEL_INDEXED = 16'd5;
  localparam logic [15:0] SEL_RGB     = 16'd2;
  localparam logic [15:0] COMP_MAX    = 16'd255;

  localparam logic [7:0] FLAG_BOLD      = 8'h01;
  localparam logic [7:0] FLAG_FAINT     = 8'h02;
  localparam logic [7:0] FLAG_ITALIC    = 8'h04;
  localparam logic [7:0] FLAG_UNDERLINE = 8'h08;
  localparam logic [7:0] FLAG_BLINK     = 8'h10;
  localparam logic [7:0] FLAG_INVERSE   = 8'h20;
  localparam logic [7:0] FLAG_HIDE      = 8'h40;
  localparam logic [7:0] FLAG_STRIKE    = 8'h80;

  typedef struct packed {
    logic [7:0]  flags;
    logic [1:0]  fg_kind;
    logic [23:0] fg_value;
    logic [1:0]  bg_kind;
    logic [23:0] bg_value;
  } rendition_t;

  typedef struct packed {
    logic ext_start;
    logic ext_back;
  } code_ctl_t;

endpackage

// ----- rtl/sgr_attribute_decoder.sv -----
// Top level of the SGR attribute decoder: extended colour sequencing and result register.
// Depends on sgrd_pkg and sgrd_code.
//
//   channel  dir  tdata                                     tuser               tlast
//   s_axis   in   [15:0] param_value                        [0] param_present   param_last
//   m_axis   out  [7:0] attr_flags, [31:8] fore_value,      [1:0] fore_kind,    -
//                 [55:32] back_value                        [3:2] back_kind
//
// One request per cycle while m_axis is not stalled: each accepted parameter updates the
// rendition registers and its result appears on m_axis in the next cycle.
// The rendition registers double as the result register; s_axis_tready_o is high
// whenever that register is empty or being taken, so input resumes as soon as a stalled result is taken.
// Reset clears the rendition to default colours with no flags set.
module sgr_attribute_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // param_value
  input  logic        s_axis_tuser_i,   // param_present
  input  logic        s_axis_tlast_i,   // param_last
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,   // attr_flags, fore_value, back_value
  output logic [3:0]  m_axis_tuser_o    // fore_kind, back_kind
);
  import sgrd_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_SEL   = 3'd1,
    PH_IDX   = 3'd2,
    PH_RED   = 3'd3,
    PH_GREEN = 3'd4,
    PH_BLUE  = 3'd5,
    PH_SKIP  = 3'd6
  } phase_e;

  rendition_t rend_q, rend_d, code_rend;
  code_ctl_t  code_ctl;
  phase_e     phase_q, phase_d;
  logic       ext_back_q, ext_back_d;
  logic [8:0] held_first_q, held_first_d;
  logic [8:0] held_second_q, held_second_d;
  logic       out_valid_q;

  logic        accept;
  logic [15:0] code;
  logic [7:0]  sat;
  logic [8:0]  held_in;
  logic        apply_code;
  logic        set_en;
  logic [1:0]  set_kind;
  logic [23:0] set_value;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign code    = s_axis_tuser_i ? s_axis_tdata_i : SGR_RESET;
  assign sat     = (s_axis_tdata_i > COMP_MAX) ? COMP_MAX[7:0] : s_axis_tdata_i[7:0];
  assign held_in = s_axis_tuser_i ? {1'b1, sat} : 9'd0;

  sgrd_code u_code (
    .code_i (code),
    .rend_i (rend_q),
    .rend_o (code_rend),
    .ctl_o  (code_ctl)
  );

  always_comb begin
    rend_d        = rend_q;
    phase_d       = PH_IDLE;
    ext_back_d    = ext_back_q;
    held_first_d  = held_first_q;
    held_second_d = held_second_q;
    apply_code    = 1'b0;
    set_en        = 1'b0;
    set_kind      = KIND_INDEXED;
    set_value     = '0;
    unique case (phase_q)
      PH_SEL: begin
        if (s_axis_tuser_i && s_axis_tdata_i == SEL_INDEXED) begin
          phase_d = PH_IDX;
        end else if (s_axis_tuser_i && s_axis_tdata_i == SEL_RGB) begin
          phase_d = PH_RED;
        end else begin
          apply_code = 1'b1;
        end
      end
      PH_IDX: begin
        if (s_axis_tuser_i && s_axis_tdata_i <= COMP_MAX) begin
          set_en    = 1'b1;
          set_kind  = KIND_INDEXED;
          set_value = {16'd0, s_axis_tdata_i[7:0]};
        end
      end
      PH_RED: begin
        if (s_axis_tuser_i) begin
          held_first_d = held_in;
          phase_d      = PH_GREEN;
        end else begin
          phase_d = PH_SKIP;
        end
      end
      PH_SKIP: begin
        held_first_d = held_in;
        phase_d      = PH_GREEN;
      end
      PH_GREEN: begin
        held_second_d = held_in;
        phase_d       = PH_BLUE;
      end
      PH_BLUE: begin
        if (s_axis_tuser_i && held_first_q[8] && held_second_q[8]) begin
          set_en    = 1'b1;
          set_kind  = KIND_RGB;
          set_value = {held_first_q[7:0], held_second_q[7:0], sat};
        end
      end
      default: apply_code = 1'b1;
    endcase

    if (apply_code) begin
      rend_d = code_rend;
      if (code_ctl.ext_start) begin
        phase_d    = PH_SEL;
        ext_back_d = code_ctl.ext_back;
      end
    end

    if (set_en) begin
      if (ext_back_q) begin
        rend_d.bg_kind  = set_kind;
        rend_d.bg_value = set_value;
      end else begin
        rend_d.fg_kind  = set_kind;
        rend_d.fg_value = set_value;
      end
    end

    if (s_axis_tlast_i) begin
      phase_d = PH_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rend_q        <= '0;
      phase_q       <= PH_IDLE;
      ext_back_q    <= 1'b0;
      held_first_q  <= '0;
      held_second_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (accept) begin
        rend_q        <= rend_d;
        phase_q       <= phase_d;
        ext_back_q    <= ext_back_d;
        held_first_q  <= held_first_d;
        held_second_q <= held_second_d;
        out_valid_q   <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {rend_q.bg_value, rend_q.fg_value, rend_q.flags};
  assign m_axis_tuser_o  = {rend_q.bg_kind, rend_q.fg_kind};

endmodule

// ----- rtl/sgrd_code.sv -----
// Plain SGR code decode: applies one code to the current rendition.
// Depends on sgrd_pkg.
module sgrd_code (
  input  logic [15:0]         code_i,
  input  sgrd_pkg::rendition_t rend_i,
  output sgrd_pkg::rendition_t rend_o,
  output sgrd_pkg::code_ctl_t  ctl_o
);
  import sgrd_pkg::*;

  logic [15:0] fg_off;
  logic [15:0] bg_off;
  logic [15:0] fgb_off;
  logic [15:0] bgb_off;

  assign fg_off  = code_i - SGR_FG_BASE;
  assign bg_off  = code_i - SGR_BG_BASE;
  assign fgb_off = code_i - SGR_FG_BRIGHT;
  assign bgb_off = code_i - SGR_BG_BRIGHT;

  always_comb begin
    rend_o = rend_i;
    ctl_o  = '0;
    unique case (code_i)
      SGR_RESET: begin
        rend_o = '0;
      end
      SGR_BOLD:       rend_o.flags = rend_i.flags | FLAG_BOLD;
      SGR_FAINT:      rend_o.flags = rend_i.flags | FLAG_FAINT;
      SGR_ITALIC:     rend_o.flags = rend_i.flags | FLAG_ITALIC;
      SGR_UNDERLINE:  rend_o.flags = rend_i.flags | FLAG_UNDERLINE;
      SGR_BLINK_SLOW,
      SGR_BLINK_FAST: rend_o.flags = rend_i.flags | FLAG_BLINK;
      SGR_INVERSE:    rend_o.flags = rend_i.flags | FLAG_INVERSE;
      SGR_HIDE:       rend_o.flags = rend_i.flags | FLAG_HIDE;
      SGR_STRIKE:     rend_o.flags = rend_i.flags | FLAG_STRIKE;
      SGR_NO_BOLD,
      SGR_NORMAL:     rend_o.flags = rend_i.flags & ~(FLAG_BOLD | FLAG_FAINT);
      SGR_NO_ITALIC:  rend_o.flags = rend_i.flags & ~FLAG_ITALIC;
      SGR_NO_UNDER:   rend_o.flags = rend_i.flags & ~FLAG_UNDERLINE;
      SGR_NO_BLINK:   rend_o.flags = rend_i.flags & ~FLAG_BLINK;
      SGR_NO_INVERSE: rend_o.flags = rend_i.flags & ~FLAG_INVERSE;
      SGR_NO_HIDE:    rend_o.flags = rend_i.flags & ~FLAG_HIDE;
      SGR_NO_STRIKE:  rend_o.flags = rend_i.flags & ~FLAG_STRIKE;
      SGR_FG_EXT: begin
        ctl_o.ext_start = 1'b1;
        ctl_o.ext_back  = 1'b0;
      end
      SGR_BG_EXT: begin
        ctl_o.ext_start = 1'b1;
        ctl_o.ext_back  = 1'b1;
      end
      SGR_FG_DEFAULT: begin
        rend_o.fg_kind  = KIND_DEFAULT;
        rend_o.fg_value = '0;
      end
      SGR_BG_DEFAULT: begin
        rend_o.bg_kind  = KIND_DEFAULT;
        rend_o.bg_value = '0;
      end
      default: begin
        if (code_i >= SGR_FG_BASE && code_i <= SGR_FG_BASE + SGR_COLOR_SPAN) begin
          rend_o.fg_kind  = KIND_INDEXED;
          rend_o.fg_value = {21'd0, fg_off[2:0]};
        end else if (code_i >= SGR_BG_BASE && code_i <= SGR_BG_BASE + SGR_COLOR_SPAN) begin
          rend_o.bg_kind  = KIND_INDEXED;
          rend_o.bg_value = {21'd0, bg_off[2:0]};
        end else if (code_i >= SGR_FG_BRIGHT &&
                     code_i <= SGR_FG_BRIGHT + SGR_COLOR_SPAN) begin
          rend_o.fg_kind  = KIND_INDEXED;
          rend_o.fg_value = {20'd0, 1'b1, fgb_off[2:0]};
        end else if (code_i >= SGR_BG_BRIGHT &&
                     code_i <= SGR_BG_BRIGHT + SGR_COLOR_SPAN) begin
          rend_o.bg_kind  = KIND_INDEXED;
          rend_o.bg_value = {20'd0, 1'b1, bgb_off[2:0]};
        end
      end
    endcase
  end

endmodule

// ----- rtl/sgrd_checker.sv -----
// Port-level checks of the SGR attribute decoder, bound to the top level.
// Depends on sgrd_pkg and sgr_attribute_decoder.
module sgrd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [55:0] m_axis_tdata_o,
  input logic [3:0]  m_axis_tuser_o
);
  import sgrd_pkg::*;

  a_ready_when_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled while result slot is free");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> m_axis_tvalid_o)
    else $error("accepted request produced no result");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tuser_o[1:0] != 2'd3 && m_axis_tuser_o[3:2] != 2'd3)
    else $error("illegal colour kind");

  a_default_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1:0] == KIND_DEFAULT |-> m_axis_tdata_o[31:8] == 24'd0)
    else $error("default foreground carries a value");

endmodule

bind sgr_attribute_decoder sgrd_checker u_sgrd_checker (.*);

// ----- verif/tb.sv -----
// Self-checking testbench for sgr_attribute_decoder: directed and random SGR parameter streams with
// stalls on both stream sides, checked against a rendition predictor kept in the bench.
// Depends on sgrd_pkg and the sgr_attribute_decoder RTL.
module tb;
  import sgrd_pkg::*;

  localparam int HOLD_OFF_CYCLES = 90;
  localparam int DRAIN_SPACING   = 170;
  localparam int ITEM_TARGET     = 700;
  localparam int MAX_REPORTS     = 10;
  localparam logic [23:0] BRIGHT_OFFSET = 24'd8;

  typedef enum logic [2:0] {
    EXT_IDLE, EXT_SELECT, EXT_INDEX, EXT_RED, EXT_GREEN, EXT_BLUE, EXT_SKIP
  } ext_state_e;

  typedef struct packed {
    logic [15:0] value;
    logic        present;
    logic        last;
    logic        drain;
  } param_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i = '0;
  logic        s_axis_tuser_i = 1'b0;
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [55:0] m_axis_tdata_o;
  logic [3:0]  m_axis_tuser_o;

  sgr_attribute_decoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  param_req_t param_q[$];
  param_req_t seq_q[$];
  rendition_t rendition_q[$];

  rendition_t pred_rend;
  ext_state_e pred_phase;
  logic       pred_back;
  logic [8:0] pred_red;
  logic [8:0] pred_green;

  param_req_t cur_req = '0;
  logic       in_busy = 1'b0;
  logic       in_fire = 1'b0;
  int         in_gap = 0;
  logic       out_fire = 1'b0;
  int         out_stall = 0;
  logic       hold_off = 1'b0;
  logic       calm;

  int taken_cnt = 0;
  int result_cnt = 0;
  int err_cnt = 0;
  int seq_cnt = 0;
  int rgb_cnt = 0;
  int index_cnt = 0;
  int drain_at = DRAIN_SPACING;

  assign calm = (taken_cnt >= 400) && (taken_cnt < 500);

  function automatic logic [7:0] sat_comp(input logic [15:0] v);
    return (v > COMP_MAX) ? 8'hFF : v[7:0];
  endfunction

  function automatic logic [8:0] hold_comp(input logic [15:0] v, input logic p);
    return p ? {1'b1, sat_comp(v)} : 9'd0;
  endfunction

  task automatic put_colour(input logic [1:0] kind, input logic [23:0] value);
    if (pred_back) begin
      pred_rend.bg_kind  = kind;
      pred_rend.bg_value = value;
    end else begin
      pred_rend.fg_kind  = kind;
      pred_rend.fg_value = value;
    end
    if (kind == KIND_RGB) rgb_cnt++;
    else index_cnt++;
  endtask

  task automatic plain_code(input logic [15:0] code);
    case (code)
      SGR_RESET:      pred_rend = '0;
      SGR_BOLD:       pred_rend.flags |= FLAG_BOLD;
      SGR_FAINT:      pred_rend.flags |= FLAG_FAINT;
      SGR_ITALIC:     pred_rend.flags |= FLAG_ITALIC;
      SGR_UNDERLINE:  pred_rend.flags |= FLAG_UNDERLINE;
      SGR_BLINK_SLOW,
      SGR_BLINK_FAST: pred_rend.flags |= FLAG_BLINK;
      SGR_INVERSE:    pred_rend.flags |= FLAG_INVERSE;
      SGR_HIDE:       pred_rend.flags |= FLAG_HIDE;
      SGR_STRIKE:     pred_rend.flags |= FLAG_STRIKE;
      SGR_NO_BOLD,
      SGR_NORMAL:     pred_rend.flags &= ~(FLAG_BOLD | FLAG_FAINT);
      SGR_NO_ITALIC:  pred_rend.flags &= ~FLAG_ITALIC;
      SGR_NO_UNDER:   pred_rend.flags &= ~FLAG_UNDERLINE;
      SGR_NO_BLINK:   pred_rend.flags &= ~FLAG_BLINK;
      SGR_NO_INVERSE: pred_rend.flags &= ~FLAG_INVERSE;
      SGR_NO_HIDE:    pred_rend.flags &= ~FLAG_HIDE;
      SGR_NO_STRIKE:  pred_rend.flags &= ~FLAG_STRIKE;
      SGR_FG_EXT: begin
        pred_back  = 1'b0;
        pred_phase = EXT_SELECT;
      end
      SGR_BG_EXT: begin
        pred_back  = 1'b1;
        pred_phase = EXT_SELECT;
      end
      SGR_FG_DEFAULT: begin
        pred_rend.fg_kind  = KIND_DEFAULT;
        pred_rend.fg_value = '0;
      end
      SGR_BG_DEFAULT: begin
        pred_rend.bg_kind  = KIND_DEFAULT;
        pred_rend.bg_value = '0;
      end
      default: begin
        if (code >= SGR_FG_BASE && code <= SGR_FG_BASE + SGR_COLOR_SPAN) begin
          pred_rend.fg_kind  = KIND_INDEXED;
          pred_rend.fg_value = {8'd0, code - SGR_FG_BASE};
        end else if (code >= SGR_BG_BASE && code <= SGR_BG_BASE + SGR_COLOR_SPAN) begin
          pred_rend.bg_kind  = KIND_INDEXED;
          pred_rend.bg_value = {8'd0, code - SGR_BG_BASE};
        end else if (code >= SGR_FG_BRIGHT && code <= SGR_FG_BRIGHT + SGR_COLOR_SPAN) begin
          pred_rend.fg_kind  = KIND_INDEXED;
          pred_rend.fg_value = {8'd0, code - SGR_FG_BRIGHT} + BRIGHT_OFFSET;
        end else if (code >= SGR_BG_BRIGHT && code <= SGR_BG_BRIGHT + SGR_COLOR_SPAN) begin
          pred_rend.bg_kind  = KIND_INDEXED;
          pred_rend.bg_value = {8'd0, code - SGR_BG_BRIGHT} + BRIGHT_OFFSET;
        end
      end
    endcase
  endtask

  task automatic decode_param(input logic [15:0] v, input logic p, input logic l);
    ext_state_e phase;
    phase = pred_phase;
    pred_phase = EXT_IDLE;
    case (phase)
      EXT_SELECT: begin
        if (p && v == SEL_INDEXED) pred_phase = EXT_INDEX;
        else if (p && v == SEL_RGB) pred_phase = EXT_RED;
        else plain_code(p ? v : SGR_RESET);
      end
      EXT_INDEX: if (p && v <= COMP_MAX) put_colour(KIND_INDEXED, {16'd0, v[7:0]});
      EXT_RED: begin
        if (p) begin
          pred_red   = hold_comp(v, 1'b1);
          pred_phase = EXT_GREEN;
        end else begin
          pred_phase = EXT_SKIP;
        end
      end
      EXT_SKIP: begin
        pred_red   = hold_comp(v, p);
        pred_phase = EXT_GREEN;
      end
      EXT_GREEN: begin
        pred_green = hold_comp(v, p);
        pred_phase = EXT_BLUE;
      end
      EXT_BLUE: begin
        if (p && pred_red[8] && pred_green[8])
          put_colour(KIND_RGB, {pred_red[7:0], pred_green[7:0], sat_comp(v)});
      end
      default: plain_code(p ? v : SGR_RESET);
    endcase
    if (l) pred_phase = EXT_IDLE;
  endtask

  task automatic check_rendition(input logic [55:0] td, input logic [3:0] tu);
    rendition_t want;
    rendition_t got;
    got.flags    = td[7:0];
    got.fg_value = td[31:8];
    got.bg_value = td[55:32];
    got.fg_kind  = tu[1:0];
    got.bg_kind  = tu[3:2];
    if (rendition_q.size() == 0) begin
      err_cnt++;
      if (err_cnt <= MAX_REPORTS)
        $display("result %0d arrived with no request pending", result_cnt);
    end else begin
      want = rendition_q.pop_front();
      if (got !== want) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("result %0d: expected flags %h fg %0d/%h bg %0d/%h, got flags %h fg %0d/%h bg %0d/%h",
                   result_cnt, want.flags, want.fg_kind, want.fg_value, want.bg_kind,
                   want.bg_value, got.flags, got.fg_kind, got.fg_value, got.bg_kind,
                   got.bg_value);
      end
    end
    result_cnt++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        out_fire = 1'b1;
        check_rendition(m_axis_tdata_o, m_axis_tuser_o);
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        in_fire = 1'b1;
        decode_param(s_axis_tdata_i, s_axis_tuser_i, s_axis_tlast_i);
        rendition_q.push_back(pred_rend);
        taken_cnt++;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_fire) begin
        in_fire = 1'b0;
        in_busy = 1'b0;
      end
      if (!in_busy) begin
        if (in_gap != 0) begin
          in_gap--;
        end else if (param_q.size() != 0 &&
                     !(param_q[0].drain && rendition_q.size() != 0)) begin
          cur_req = param_q.pop_front();
          in_busy = 1'b1;
          in_gap  = calm ? 0 : $urandom_range(0, 5);
        end
      end
      s_axis_tvalid_i <= in_busy;
      s_axis_tdata_i  <= cur_req.value;
      s_axis_tuser_i  <= cur_req.present;
      s_axis_tlast_i  <= cur_req.last;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_fire) begin
        out_fire  = 1'b0;
        out_stall = calm ? 0 : $urandom_range(0, 5);
      end else if (out_stall != 0) begin
        out_stall--;
      end
      m_axis_tready_i <= (out_stall == 0) && !hold_off;
    end
  end

  initial begin
    wait (taken_cnt >= 250);
    hold_off = 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
    hold_off = 1'b0;
  end

  task automatic add_param(input logic [15:0] v, input logic p);
    param_req_t r;
    r.value   = v;
    r.present = p;
    r.last    = 1'b0;
    r.drain   = 1'b0;
    seq_q.push_back(r);
  endtask

  task automatic close_seq(input logic allow_cut);
    if (allow_cut && seq_q.size() > 1 && $urandom_range(0, 6) == 0)
      seq_q[$urandom_range(0, seq_q.size() - 2)].last = 1'b1;
    seq_q[seq_q.size() - 1].last = 1'b1;
    if (param_q.size() >= drain_at) begin
      seq_q[0].drain = 1'b1;
      drain_at += DRAIN_SPACING;
    end
    while (seq_q.size() != 0) param_q.push_back(seq_q.pop_front());
    seq_cnt++;
  endtask

  function automatic logic [15:0] ext_code();
    return ($urandom_range(0, 1) != 0) ? SGR_BG_EXT : SGR_FG_EXT;
  endfunction

  function automatic logic [15:0] pick_comp();
    case ($urandom_range(0, 7))
      0: return 16'($urandom_range(0, 65535));
      1: return COMP_MAX;
      2: return COMP_MAX + 16'd1;
      default: return 16'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic random_seq();
    int parts;
    int kind;
    parts = $urandom_range(1, 4);
    if ($urandom_range(0, 9) < 3) begin
      repeat ($urandom_range(1, 6))
        add_param(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
    end else begin
      repeat (parts) begin
        kind = $urandom_range(0, 9);
        if (kind < 5) begin
          add_param(($urandom_range(0, 19) == 0) ? 16'($urandom_range(0, 65535))
                                                 : 16'($urandom_range(0, 109)),
                    $urandom_range(0, 15) != 0);
        end else if (kind < 7) begin
          add_param(ext_code(), 1'b1);
          add_param(SEL_INDEXED, 1'b1);
          add_param(pick_comp(), $urandom_range(0, 7) != 0);
        end else if (kind < 9) begin
          add_param(ext_code(), 1'b1);
          add_param(SEL_RGB, 1'b1);
          if ($urandom_range(0, 3) == 0) add_param(16'($urandom_range(0, 65535)), 1'b0);
          repeat (3) add_param(pick_comp(), $urandom_range(0, 9) != 0);
        end else begin
          add_param(ext_code(), 1'b1);
          add_param(16'($urandom_range(0, 109)), $urandom_range(0, 5) != 0);
        end
      end
    end
    close_seq(1'b1);
  endtask

  initial begin
    pred_rend  = '0;
    pred_phase = EXT_IDLE;
    pred_back  = 1'b0;
    pred_red   = '0;
    pred_green = '0;

    // set every flag, then clear bold and faint together
    add_param(SGR_BOLD, 1'b1);
    add_param(SGR_FAINT, 1'b1);
    add_param(SGR_ITALIC, 1'b1);
    add_param(SGR_UNDERLINE, 1'b1);
    add_param(SGR_BLINK_FAST, 1'b1);
    add_param(SGR_INVERSE, 1'b1);
    add_param(SGR_HIDE, 1'b1);
    add_param(SGR_STRIKE, 1'b1);
    close_seq(1'b0);
    add_param(SGR_NO_BOLD, 1'b1);
    close_seq(1'b0);
    // indexed colour at the top of the palette
    add_param(SGR_FG_EXT, 1'b1);
    add_param(SEL_INDEXED, 1'b1);
    add_param(COMP_MAX, 1'b1);
    close_seq(1'b0);
    // rgb with an empty colour-space slot and saturating components
    add_param(SGR_BG_EXT, 1'b1);
    add_param(SEL_RGB, 1'b1);
    add_param(16'hFFFF, 1'b0);
    add_param(16'd300, 1'b1);
    add_param(16'd0, 1'b1);
    add_param(16'hFFFF, 1'b1);
    close_seq(1'b0);
    // unknown selector handled as a plain code
    add_param(SGR_BG_EXT, 1'b1);
    add_param(SGR_INVERSE, 1'b1);
    close_seq(1'b0);
    // extended colour cut short by the end of the sequence
    add_param(SGR_FG_EXT, 1'b1);
    add_param(SEL_RGB, 1'b1);
    add_param(16'd10, 1'b1);
    close_seq(1'b0);
    // empty slot resets the rendition
    add_param(16'hFFFF, 1'b0);
    close_seq(1'b0);

    while (param_q.size() < ITEM_TARGET) random_seq();

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (param_q.size() != 0 || in_busy || rendition_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (rendition_q.size() != 0) begin
      err_cnt++;
      $display("%0d expected results never arrived", rendition_q.size());
    end

    $display("Run covered %0d parameters in %0d sequences, %0d results checked.",
             taken_cnt, seq_cnt, result_cnt);
    $display("Colour updates predicted: %0d rgb, %0d indexed; %0d mismatches.",
             rgb_cnt, index_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #(12 * 200000);
    $display("Timeout: run did not finish.");
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/sgrd_pkg.sv
rtl/sgrd_code.sv
rtl/sgr_attribute_decoder.sv
rtl/sgrd_checker.sv
verif/tb.sv
